// File: design/srt_pkg.sv
package srt_pkg;

    // field widths of the channel words
    localparam int FUNC_W  = 1;
    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 13;

    // default table size
    localparam int TABLE_DEPTH_DEF = 4096;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

endpackage

// File: design/srt_if.sv
// input items: table writes and lookups
interface srt_req_if
    import srt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] entry_value;
    logic [DATA_W-1:0] lookup_key;

    modport source (output valid, func, entry_index, entry_value, lookup_key, input ready);
    modport sink   (input valid, func, entry_index, entry_value, lookup_key, output ready);
endinterface

// results: one range index per lookup
interface srt_rsp_if
    import srt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] range_index;

    modport source (output valid, range_index, input ready);
    modport sink   (input valid, range_index, output ready);
endinterface

// entry count register writes
interface srt_cfg_if
    import srt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: design/srt_mem.sv
// single-port table memory, registered read data (read-first)
module srt_mem
    import srt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/srt_ctrl.sv
// search sequencer: last-entry check, then binary search, one probe a cycle
module srt_ctrl
    import srt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    srt_req_if.sink           req,
    srt_rsp_if.source         rsp,
    srt_cfg_if.sink           cfg,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [DATA_W-1:0] mem_wdata,
    input  logic [DATA_W-1:0] mem_rdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]  res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]  rsp_data_reg, rsp_data_next;

    logic              accept;
    logic              slot_free;
    logic [CNT_W-1:0]  n_clamp;
    logic              idx_ok;
    logic [CNT_W-1:0]  mem_idx;
    logic [ADDR_W+CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0]  lo_w, hi_w;
    logic [CNT_W:0]    mid_sum;
    logic              done;
    logic [CNT_W-1:0]  done_val;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    // entries in use, clipped to the table size
    assign n_clamp = (int'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_reg;
    assign idx_ok  = int'(req.entry_index) < TABLE_DEPTH;

    // table index to memory address
    assign idx_ext   = {{ADDR_W{1'b0}}, mem_idx};
    assign mem_addr  = idx_ext[ADDR_W-1:0];
    assign mem_wdata = req.entry_value;

    assign mid_sum = {1'b0, lo_w} + {1'b0, hi_w};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_idx    = mid_reg;
        lo_w       = lo_reg;
        hi_w       = hi_reg;
        done       = 1'b0;
        done_val   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_WRITE)
                    begin
                        mem_we  = idx_ok;
                        mem_idx = {1'b0, req.entry_index};
                    end
                    else
                    begin
                        key_next = req.lookup_key;
                        n_next   = n_clamp;
                        if (n_clamp == '0)
                        begin
                            res_next   = '0;
                            state_next = ST_HOLD;
                        end
                        else
                        begin
                            // fetch the last entry in use
                            mem_idx    = n_clamp - CNT_W'(1);
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (mem_rdata <= key_reg)
                begin
                    done     = 1'b1;
                    done_val = n_reg;
                end
                else
                begin
                    // answer lies in [1, n-1]
                    lo_w = CNT_W'(1);
                    hi_w = n_reg - CNT_W'(1);
                    if (lo_w < hi_w)
                    begin
                        mid_next   = mid_sum[CNT_W:1];
                        mem_idx    = mid_sum[CNT_W:1];
                        lo_next    = lo_w;
                        hi_next    = hi_w;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        done     = 1'b1;
                        done_val = lo_w;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (mem_rdata > key_reg)
                begin
                    lo_w = lo_reg;
                    hi_w = mid_reg;
                end
                else
                begin
                    lo_w = mid_reg + CNT_W'(1);
                    hi_w = hi_reg;
                end
                if (lo_w < hi_w)
                begin
                    mid_next = mid_sum[CNT_W:1];
                    mem_idx  = mid_sum[CNT_W:1];
                    lo_next  = lo_w;
                    hi_next  = hi_w;
                end
                else
                begin
                    done     = 1'b1;
                    done_val = lo_w;
                end
            end
            ST_HOLD:
            begin
                done     = 1'b1;
                done_val = res_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result hand-off to the output register
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        if (done)
        begin
            if (slot_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_data_next  = done_val;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = done_val;
                state_next = ST_HOLD;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.data;
            end
        end
    end

    // search payload
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.range_index = rsp_data_reg;

endmodule

// File: design/sorted_range_table_lookup.sv
// channel  dir  word                                             accepted when
// req      in   func, entry_index, entry_value, lookup_key       req.valid && req.ready
// rsp      out  range_index                                      rsp.valid && rsp.ready
// cfg      in   data (entry count)                               cfg.valid && cfg.ready
//
// A write word is taken while idle; a lookup checks the last entry in use, then makes up to ceil(log2(n-1))
// search probes for n entries in use when the last entry exceeds the key, one dependent
// probe per cycle through the table memory; no new word is taken until the lookup is done.
// The memory is not cleared at reset; only the entry count and control reset.
// A finished result waits in the output register; while it is not taken the
// next lookup may run and then holds its result until the register frees.
module sorted_range_table_lookup
    import srt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    srt_req_if.sink   req,
    srt_rsp_if.source rsp,
    srt_cfg_if.sink   cfg
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    // search sequencer
    srt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // range start table
    srt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .wr_en (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srt_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYC    = 24;
    localparam int RANDOM_ITEMS = 1100;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    logic clk;
    logic rst_n;

    srt_req_if req_if ();
    srt_rsp_if rsp_if ();
    srt_cfg_if cfg_if ();

    sorted_range_table_lookup DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // table contents and entry count as the block should hold them
    logic [DATA_W-1:0] table_starts [DEPTH];
    logic [CNT_W-1:0]  entry_count_reg;

    logic [CNT_W-1:0]  pending_ranges [$];
    int                mismatches;
    int                burst_left;
    int                items_sent;

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int entries_in_use();
        return (entry_count_reg > DEPTH) ? DEPTH : int'(entry_count_reg);
    endfunction

    // upper bound from index 1; the last entry decides first
    function automatic logic [CNT_W-1:0] range_index_for_key(input logic [DATA_W-1:0] key);
        int n;
        n = entries_in_use();
        if (n == 0)
            return '0;
        if (table_starts[n-1] <= key)
            return CNT_W'(n);
        for (int i = 1; i < n; i++)
            if (table_starts[i] > key)
                return CNT_W'(i);
        return CNT_W'(n);
    endfunction

    // random keys, keys at, just below and just above stored starts, plus the extremes
    function automatic logic [DATA_W-1:0] pick_key();
        int n;
        int sel;
        n = entries_in_use();
        sel = $urandom_range(9, 0);
        if (n == 0 || sel < 3)
            return $urandom;
        if (sel == 3)
            return ($urandom_range(1, 0) != 0) ? '0 : ALL_ONES;
        return table_starts[$urandom_range(n - 1, 0)] + DATA_W'($urandom_range(2, 0)) - 1;
    endfunction

    function automatic void report_mismatch(input string what,
                                            input logic [CNT_W-1:0] want,
                                            input logic [CNT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // one request word; sender runs in bursts with random gaps
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(16, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(7, 1);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.func        <= func;
        req_if.entry_index <= idx;
        req_if.entry_value <= value;
        req_if.lookup_key  <= key;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        // word taken at this edge
        if (func == FUNC_LOOKUP)
            pending_ranges.push_back(range_index_for_key(key));
        else
            table_starts[idx] = value;
        items_sent++;
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        send_word(FUNC_WRITE, idx, value, $urandom);
    endtask

    task automatic lookup(input logic [DATA_W-1:0] key);
        send_word(FUNC_LOOKUP, IDX_W'($urandom), $urandom, key);
    endtask

    // count changes only once the block has gone quiet
    task automatic set_entry_count(input logic [CNT_W-1:0] value);
        req_if.valid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        entry_count_reg = value;
        burst_left = 0;
    endtask

    // entries 1..n-1 non-decreasing; entry 0 sometimes out of order
    task automatic load_table(input int n);
        longint unsigned acc;
        longint unsigned step_max;
        if ($urandom_range(3, 0) == 0)
        begin
            step_max = 3;
            acc = $urandom_range(32'hFFFF_0000, 0);
        end
        else
        begin
            step_max = 64'hFFFF_FFFF / (n + 1);
            acc = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            acc += $urandom_range(32'(step_max), 0);
            write_entry(IDX_W'(i), DATA_W'(acc));
        end
        if (n > 0 && $urandom_range(2, 0) == 0)
            write_entry('0, $urandom);
    endtask

    // a write that keeps entries 1..n-1 non-decreasing: in order, at entry 0, or past the entries in use
    task automatic write_in_order(input int n);
        int sel;
        int idx;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        sel = $urandom_range(3, 0);
        if (sel == 0 && n < DEPTH)
            write_entry(IDX_W'($urandom_range(DEPTH - 1, n)), $urandom);
        else if (sel == 1 || n < 2)
            write_entry('0, $urandom);
        else
        begin
            idx = $urandom_range(n - 1, 1);
            lo = (idx > 1) ? table_starts[idx-1] : '0;
            hi = (idx < n - 1) ? table_starts[idx+1] : ALL_ONES;
            write_entry(IDX_W'(idx), $urandom_range(hi, lo));
        end
    endtask

    task automatic test_empty_table();
        lookup('0);
        lookup(ALL_ONES);
        write_entry(IDX_W'(7), 32'h1234_5678);
        lookup(32'h1234_5678);
        set_entry_count('0);
    endtask

    task automatic test_single_entry();
        write_entry('0, 32'h0000_1000);
        set_entry_count(CNT_W'(1));
        lookup(32'h0000_0FFF);
        lookup(32'h0000_1000);
        lookup(ALL_ONES);
    endtask

    // entry 0 out of order, a duplicate pair, all-ones at the end
    task automatic test_small_table();
        write_entry(IDX_W'(0), 32'h8000_0000);
        write_entry(IDX_W'(1), 32'd10);
        write_entry(IDX_W'(2), 32'd20);
        write_entry(IDX_W'(3), 32'd20);
        write_entry(IDX_W'(4), ALL_ONES);
        set_entry_count(CNT_W'(5));
        lookup('0);
        lookup(32'd9);
        lookup(32'd10);
        lookup(32'd19);
        lookup(32'd20);
        lookup(32'd21);
        lookup(ALL_ONES - 1);
        lookup(ALL_ONES);
    endtask

    // count above the depth, then exactly the depth; keys at or above the
    // last entry are decided by that entry alone
    task automatic test_full_table();
        write_entry(IDX_W'(DEPTH - 1), 32'hF000_0000);
        set_entry_count('1);
        lookup(32'hF000_0000);
        lookup(ALL_ONES);
        set_entry_count(CNT_W'(DEPTH));
        lookup(32'hF000_0000);
        lookup(ALL_ONES);
    endtask

    task automatic test_random_tables();
        int start;
        int n;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // mostly small tables, now and then a few hundred entries
            case ($urandom_range(11, 0))
                0:       n = 0;
                1:       n = 2;
                2:       n = $urandom_range(400, 64);
                default: n = $urandom_range(24, 1);
            endcase
            set_entry_count(CNT_W'(n));
            load_table(n);
            repeat ($urandom_range(60, 10))
            begin
                if ($urandom_range(3, 0) != 0)
                    lookup(pick_key());
                else
                    write_in_order(n);
            end
        end
    endtask

    // result side stalls on its own pattern
    initial
    begin
        stall_mode_t mode;
        int left;
        int phase;
        int stall_len;
        int period;
        rsp_if.ready <= 1'b0;
        mode = STALL_NONE;
        left = 0;
        phase = 0;
        stall_len = 1;
        period = 2;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(2, 0));
                left = $urandom_range(256, 32);
                stall_len = $urandom_range(8, 1);
                period = stall_len + $urandom_range(12, 1);
                phase = 0;
            end
            left--;
            phase = (phase + 1) % period;
            case (mode)
                STALL_NONE:   rsp_if.ready <= 1'b1;
                STALL_RANDOM: rsp_if.ready <= ($urandom_range(2, 0) != 0);
                default:      rsp_if.ready <= (phase >= stall_len);
            endcase
        end
    end

    // compare each range index with the oldest prediction
    always @(posedge clk)
    begin
        logic [CNT_W-1:0] want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_ranges.size() == 0)
                report_mismatch("range index with no lookup pending", '0, rsp_if.range_index);
            else
            begin
                want = pending_ranges.pop_front();
                if (rsp_if.range_index !== want)
                    report_mismatch("range_index", want, rsp_if.range_index);
            end
        end
    end

    initial
    begin
        req_if.valid       <= 1'b0;
        req_if.func        <= FUNC_WRITE;
        req_if.entry_index <= '0;
        req_if.entry_value <= '0;
        req_if.lookup_key  <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        rst_n              <= 1'b0;
        mismatches = 0;
        burst_left = 0;
        items_sent = 0;
        entry_count_reg = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_single_entry();
        test_small_table();
        test_full_table();
        test_random_tables();

        // drain
        req_if.valid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && pending_ranges.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
